// File: sv/bmdl_pkg.sv
package bmdl_pkg;

	// Number of keys in the matrix
	localparam int KEY_COUNT = 16;
	// Width of the raw scan word and of the hold timer
	localparam int RAW_W = 16;
	localparam int TIMER_W = 16;
	// Reload used after reset
	localparam logic [TIMER_W-1:0] TICKS_RESET = 16'd10;

	typedef enum logic [1:0] {
		CMD_SCAN  = 2'd0,
		CMD_PRESS = 2'd1,
		CMD_LONG  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Per-lane control for one accepted word
	typedef struct packed {
		logic               scan;
		logic               clr_press;
		logic               clr_long;
		logic [TIMER_W-1:0] reload;
	} lane_ctl_t;

	// Word position (MSB first) that feeds a given key
	function automatic logic [3:0] pos_of_key(input logic [3:0] k);
		logic [3:0] p;
		begin
			case (k[3:2])
				2'd0: p = 4'd7 - k;
				2'd1: p = k - 4'd4;
				// 23 - k, taken modulo 16
				2'd2: p = 4'd7 - k;
				2'd3: p = k - 4'd4;
				default: p = 4'd0;
			endcase
			return p;
		end
	endfunction

endpackage

// File: sv/bmdl_lane.sv
module bmdl_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bmdl_pkg::lane_ctl_t  ctl,
	input  logic                 sample,
	output logic                 press_flag,
	output logic                 long_flag
);

	logic                          newest_q;
	logic                          older_q;
	logic                          oldest_q;
	logic                          level_q;
	logic [bmdl_pkg::TIMER_W-1:0]  timer_q;
	logic                          press_q;
	logic                          long_q;
	logic                          stable;
	logic [bmdl_pkg::TIMER_W-1:0]  timer_dec;

	// Three samples agree once this word's sample is shifted in
	assign stable    = (sample == newest_q) && (newest_q == older_q);
	assign timer_dec = timer_q - bmdl_pkg::TIMER_W'(1);

	// Advance samples, level and hold timer on a scan word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q <= 1'b0;
			older_q  <= 1'b0;
			oldest_q <= 1'b0;
			level_q  <= 1'b0;
			timer_q  <= '0;
		end else if (ctl.scan) begin
			newest_q <= sample;
			older_q  <= newest_q;
			oldest_q <= older_q;
			if (stable) begin
				if (older_q != level_q) begin
					level_q <= older_q;
					if (older_q) begin
						timer_q <= ctl.reload;
					end
				end else if (timer_dec == '0) begin
					timer_q <= ctl.reload;
				end else begin
					timer_q <= timer_dec;
				end
			end
		end
	end

	// Set sticky flags on scan, drop them on query or clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q <= 1'b0;
			long_q  <= 1'b0;
		end else begin
			if (ctl.scan && stable && (older_q != level_q) && older_q) begin
				press_q <= 1'b1;
			end else if (ctl.clr_press) begin
				press_q <= 1'b0;
			end
			if (ctl.scan && stable && (older_q == level_q) && level_q
				&& (timer_dec == '0)) begin
				long_q <= 1'b1;
			end else if (ctl.clr_long) begin
				long_q <= 1'b0;
			end
		end
	end

	assign press_flag = press_q;
	assign long_flag  = long_q;

	// A press flag is only raised by a scan word
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(press_q) |-> $past(ctl.scan))
		else $error("press flag set without a scan");

	// A long-press flag needs the key held down
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(long_q) |-> $past(level_q))
		else $error("long flag set while released");

endmodule

// File: sv/bmdl_merge.sv
module bmdl_merge #(
	parameter int KEY_COUNT = bmdl_pkg::KEY_COUNT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [1:0]             cmd,
	input  logic [3:0]             key_index,
	input  logic [KEY_COUNT-1:0]   press_vec,
	input  logic [KEY_COUNT-1:0]   long_vec,
	output logic                   space,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   flag_out
);

	localparam int KEY_W = $clog2(KEY_COUNT);

	logic       flag_d;
	logic       e0_q;
	logic       e1_q;
	logic [1:0] count_q;
	logic       pop;
	logic [KEY_W-1:0] sel;

	assign sel = key_index[KEY_W-1:0];

	// Pick the addressed flag before the lanes clear it
	always_comb begin
		case (bmdl_pkg::cmd_t'(cmd))
			bmdl_pkg::CMD_PRESS: flag_d = press_vec[sel];
			bmdl_pkg::CMD_LONG:  flag_d = long_vec[sel];
			default:             flag_d = 1'b0;
		endcase
	end

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign flag_out  = e0_q;
	assign space     = (count_q != 2'd2);

	// Two-entry result queue: hold, advance, drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			e0_q    <= 1'b0;
			e1_q    <= 1'b0;
		end else begin
			if (push && !pop) begin
				if (count_q == 2'd0) begin
					e0_q <= flag_d;
				end else begin
					e1_q <= flag_d;
				end
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				e0_q    <= e1_q;
				count_q <= count_q - 2'd1;
			end else if (pop && push) begin
				if (count_q == 2'd1) begin
					e0_q <= flag_d;
				end else begin
					e0_q <= e1_q;
					e1_q <= flag_d;
				end
			end
		end
	end

	// Queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue overflow");

	// No push into a full queue
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !push)
		else $error("push into full queue");

endmodule

// File: sv/button_matrix_debounce_longpress_core.sv
// Sixteen-key debounce with press and long-press (auto-repeat) flags.
// Input channel (in_valid/in_ready) carries one word: cmd, raw_word,
// key_index. A scan word shifts a new active-low sample into every key,
// all sixteen lanes updating together; query words return a flag and clear
// it; a clear word drops both flags of one key.
// Output channel (out_valid/out_ready) returns one word per input word,
// flag_out, in order. Each result is registered into the result queue on acceptance.
// Throughput is one word per cycle: each lane does its whole update in the
// accepting cycle, and a two-entry result queue lets the input keep flowing
// while a result waits. When the receiver stalls, the queue fills and
// in_ready drops after two pending results.
// Configuration port (cfg_valid/cfg_ready/cfg_data) writes long_press_ticks;
// it is always ready and should be written only while the block is idle.
// Reset clears all samples, levels, timers and flags, empties the queue and
// sets long_press_ticks to 10.
module button_matrix_debounce_longpress_core #(
	parameter int KEY_COUNT = bmdl_pkg::KEY_COUNT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] raw_word,
	input  logic [3:0]  key_index,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        flag_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int KEY_W = $clog2(KEY_COUNT);

	logic [bmdl_pkg::TIMER_W-1:0] ticks_q;
	logic [bmdl_pkg::TIMER_W-1:0] reload;
	logic                         accept;
	logic                         space;
	logic [KEY_COUNT-1:0]         press_vec;
	logic [KEY_COUNT-1:0]         long_vec;
	bmdl_pkg::cmd_t               cmd_c;

	assign cfg_ready = 1'b1;
	assign in_ready  = space;
	assign accept    = in_valid && space;
	assign cmd_c     = bmdl_pkg::cmd_t'(cmd);
	assign reload    = (ticks_q == '0) ? bmdl_pkg::TIMER_W'(1) : ticks_q;

	// Hold the long-press reload register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= bmdl_pkg::TICKS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ticks_q <= cfg_data;
		end
	end

	// One lane per key
	for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
		bmdl_pkg::lane_ctl_t ctl;
		logic                hit;
		logic                sample;

		assign hit = (key_index[KEY_W-1:0] == KEY_W'(k));
		assign sample = ~raw_word[4'd15 - bmdl_pkg::pos_of_key(4'(k))];
		assign ctl.scan      = accept && (cmd_c == bmdl_pkg::CMD_SCAN);
		assign ctl.clr_press = accept && hit
			&& ((cmd_c == bmdl_pkg::CMD_PRESS) || (cmd_c == bmdl_pkg::CMD_CLEAR));
		assign ctl.clr_long  = accept && hit
			&& ((cmd_c == bmdl_pkg::CMD_LONG) || (cmd_c == bmdl_pkg::CMD_CLEAR));
		assign ctl.reload    = reload;

		bmdl_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.sample     (sample),
			.press_flag (press_vec[k]),
			.long_flag  (long_vec[k])
		);
	end

	// Merge the addressed lane's flag into the result queue
	bmdl_merge #(
		.KEY_COUNT (KEY_COUNT)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.cmd       (cmd),
		.key_index (key_index),
		.press_vec (press_vec),
		.long_vec  (long_vec),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flag_out  (flag_out)
	);

	// Reload is never zero
	assert property (@(posedge clk) disable iff (!arst_n)
		reload != '0)
		else $error("zero reload");

endmodule

// File: bench/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           in_valid = 1'b0;
	logic           in_ready;
	bmdl_pkg::cmd_t in_cmd = bmdl_pkg::CMD_SCAN;
	logic [15:0]    in_raw = 16'hFFFF;
	logic [3:0]     in_key = 4'd0;
	logic           out_valid;
	logic           out_ready = 1'b1;
	logic           flag_out;
	logic           cfg_valid = 1'b0;
	logic           cfg_ready;
	logic [15:0]    cfg_data = 16'd0;

	// Idling switches for the sender and the receiver
	bit in_idle_en = 1'b1;
	bit out_idle_en = 1'b1;

	// Predicted key state, one bit or timer per key
	logic [15:0] smp_new, smp_mid, smp_old;
	logic [15:0] key_level, press_seen, long_seen;
	logic [15:0] hold_left [bmdl_pkg::KEY_COUNT];
	logic [15:0] reload_ticks;

	// Flags still owed by the block, oldest first
	logic pending_flags [$];
	logic want_flag;

	int fails = 0;
	int quiet_cycles = 0;
	int n_scans = 0;
	int n_queries = 0;
	int n_press_hits = 0;
	int n_long_hits = 0;
	int n_settings = 0;

	button_matrix_debounce_longpress_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (in_cmd),
		.raw_word  (in_raw),
		.key_index (in_key),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.flag_out  (flag_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Key fed by a word position, counted from bit 15
	function automatic logic [3:0] key_at_pos(int p);
		case (p / 4)
			0: return 4'(p + 4);
			1: return 4'(7 - p);
			2: return 4'(p + 4);
			default: return 4'(23 - p);
		endcase
	endfunction

	function automatic void clear_key_state();
		reload_ticks = bmdl_pkg::TICKS_RESET;
		smp_new = '0;
		smp_mid = '0;
		smp_old = '0;
		key_level = '0;
		press_seen = '0;
		long_seen = '0;
		for (int n = 0; n < bmdl_pkg::KEY_COUNT; n++)
			hold_left[n] = '0;
	endfunction

	// Advance the key state by one word and return the flag it reads
	function automatic logic apply_key_word(bmdl_pkg::cmd_t c, logic [15:0] raw,
		logic [3:0] k);
		logic        flag;
		logic [15:0] fresh;
		logic [15:0] reload;
		flag = 1'b0;
		fresh = '0;
		reload = (reload_ticks == 16'd0) ? 16'd1 : reload_ticks;
		case (c)
			bmdl_pkg::CMD_SCAN: begin
				smp_old = smp_mid;
				smp_mid = smp_new;
				for (int p = 0; p < 16; p++)
					fresh[key_at_pos(p)] = ~raw[15 - p];
				smp_new = fresh;
				for (int n = 0; n < bmdl_pkg::KEY_COUNT; n++) begin
					if (smp_new[n] == smp_mid[n] && smp_mid[n] == smp_old[n]) begin
						if (smp_old[n] != key_level[n]) begin
							key_level[n] = smp_old[n];
							if (key_level[n]) begin
								hold_left[n] = reload;
								press_seen[n] = 1'b1;
							end
						end else begin
							// count down even while released; wrap and reload at zero
							hold_left[n] = hold_left[n] - 16'd1;
							if (hold_left[n] == 16'd0) begin
								hold_left[n] = reload;
								if (key_level[n])
									long_seen[n] = 1'b1;
							end
						end
					end
				end
			end
			bmdl_pkg::CMD_PRESS: begin
				flag = press_seen[k];
				press_seen[k] = 1'b0;
			end
			bmdl_pkg::CMD_LONG: begin
				flag = long_seen[k];
				long_seen[k] = 1'b0;
			end
			default: begin
				press_seen[k] = 1'b0;
				long_seen[k] = 1'b0;
			end
		endcase
		return flag;
	endfunction

	// Offer one word, hold it until taken, then log the flag it should return
	task automatic send_word(bmdl_pkg::cmd_t c, logic [15:0] raw, logic [3:0] k);
		logic flag;
		@(negedge clk);
		// Idle at random before offering, with a chance of 22 in a hundred per try
		while (in_idle_en && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_cmd <= c;
		in_raw <= raw;
		in_key <= k;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		flag = apply_key_word(c, raw, k);
		pending_flags.push_back(flag);
		if (c == bmdl_pkg::CMD_SCAN)
			n_scans++;
		else
			n_queries++;
		if (flag && c == bmdl_pkg::CMD_PRESS)
			n_press_hits++;
		if (flag && c == bmdl_pkg::CMD_LONG)
			n_long_hits++;
	endtask

	// Drop valid and hold off until every owed word has come back
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_flags.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_ticks(logic [15:0] ticks);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= ticks;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reload_ticks = ticks;
		n_settings++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Queries and a clear straight after reset
	task automatic test_reset_queries();
		send_word(bmdl_pkg::CMD_PRESS, 16'hFFFF, 4'd0);
		send_word(bmdl_pkg::CMD_LONG, 16'h0000, 4'd15);
		send_word(bmdl_pkg::CMD_CLEAR, 16'hFFFF, 4'd5);
	endtask

	// All keys pressed at once, with a one-tick repeat
	task automatic test_all_pressed();
		drain_results();
		write_ticks(16'd1);
		repeat (4) send_word(bmdl_pkg::CMD_SCAN, 16'h0000, 4'd0);
		send_word(bmdl_pkg::CMD_PRESS, 16'hFFFF, 4'd4);
		send_word(bmdl_pkg::CMD_LONG, 16'hFFFF, 4'd11);
		send_word(bmdl_pkg::CMD_CLEAR, 16'hFFFF, 4'd8);
		send_word(bmdl_pkg::CMD_PRESS, 16'hFFFF, 4'd8);
		send_word(bmdl_pkg::CMD_LONG, 16'hFFFF, 4'd8);
	endtask

	// A press seen on only two samples must not debounce
	task automatic test_glitch_rejected();
		repeat (3) send_word(bmdl_pkg::CMD_SCAN, 16'hFFFF, 4'd0);
		repeat (2) send_word(bmdl_pkg::CMD_SCAN, 16'h7FFF, 4'd0);
		send_word(bmdl_pkg::CMD_SCAN, 16'hFFFF, 4'd0);
		send_word(bmdl_pkg::CMD_PRESS, 16'hFFFF, 4'd4);
	endtask

	// A reload of zero behaves as one
	task automatic test_zero_reload();
		drain_results();
		write_ticks(16'd0);
		repeat (4) send_word(bmdl_pkg::CMD_SCAN, 16'hFFFE, 4'd0);
		send_word(bmdl_pkg::CMD_LONG, 16'hFFFF, 4'd8);
		send_word(bmdl_pkg::CMD_PRESS, 16'hFFFF, 4'd8);
	endtask

	// Mostly steady key patterns that change a key at a time, with noise and queries
	task automatic run_random_phase(int words, logic [15:0] ticks, bit idling);
		logic [15:0]    held;
		logic [15:0]    raw;
		bmdl_pkg::cmd_t c;
		int             roll;
		drain_results();
		write_ticks(ticks);
		in_idle_en = idling;
		out_idle_en = idling;
		held = 16'($urandom);
		for (int i = 0; i < words; i++) begin
			roll = $urandom_range(99);
			if (roll < 62) begin
				if ($urandom_range(99) < 12)
					held ^= 16'h1 << $urandom_range(15);
				raw = ($urandom_range(99) < 8) ? 16'($urandom) : held;
				send_word(bmdl_pkg::CMD_SCAN, raw, 4'($urandom));
			end else begin
				roll = $urandom_range(9);
				c = (roll < 4) ? bmdl_pkg::CMD_PRESS :
					(roll < 8) ? bmdl_pkg::CMD_LONG : bmdl_pkg::CMD_CLEAR;
				send_word(c, 16'($urandom), 4'($urandom));
			end
			if (i % 240 == 239)
				drain_results();
		end
	endtask

	task automatic test_random_phases();
		run_random_phase(300, 16'd1, 1'b1);
		run_random_phase(300, 16'd3, 1'b0);
		run_random_phase(300, bmdl_pkg::TICKS_RESET, 1'b1);
		run_random_phase(300, 16'd2, 1'b1);
		run_random_phase(200, 16'hFFFF, 1'b1);
		run_random_phase(200, 16'd0, 1'b1);
		run_random_phase(300, 16'($urandom_range(4, 20)), 1'b1);
	endtask

	// Stall the receiver at random
	always @(negedge clk)
		out_ready <= out_idle_en ? ($urandom_range(99) >= 22) : 1'b1;

	// Compare each returned word with the oldest owed flag
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_flags.size() == 0) begin
				$display("%0t: result word with none owed, expected nothing, got flag_out %0b",
					$time, flag_out);
				fails++;
			end else begin
				want_flag = pending_flags.pop_front();
				if (flag_out !== want_flag) begin
					$display("%0t: flag_out mismatch, expected %0b, got %0b",
						$time, want_flag, flag_out);
					fails++;
				end
			end
		end
	end

	// End the run if no word moves on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL button_matrix_debounce_longpress_core");
				$finish;
			end
		end
	end

	initial begin
		clear_key_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_queries();
		test_all_pressed();
		test_glitch_rejected();
		test_zero_reload();
		test_random_phases();
		drain_results();
		$display("Ran %0d scan words and %0d query or clear words over %0d tick settings,",
			n_scans, n_queries, n_settings);
		$display("reading back %0d set press flags and %0d set long-press flags.",
			n_press_hits, n_long_hits);
		if (fails == 0)
			$display("PASS button_matrix_debounce_longpress_core");
		else
			$display("FAIL button_matrix_debounce_longpress_core");
		$finish;
	end

endmodule

// File: files.f
sv/bmdl_pkg.sv
sv/bmdl_lane.sv
sv/bmdl_merge.sv
sv/button_matrix_debounce_longpress_core.sv
bench/tb.sv
